[rtl/core/texture_triangle_interpolated_sampler_core_assert.svh]
// Assertion macros for the sampler core, used by the fetch module
`ifndef TEXTURE_TRIANGLE_INTERPOLATED_SAMPLER_CORE_ASSERT_SVH
`define TEXTURE_TRIANGLE_INTERPOLATED_SAMPLER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, ignored while arst_n is low
`define TTIS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sampler core: same-cycle check failed");

// next-cycle implication, sampled on clk, ignored while arst_n is low
`define TTIS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sampler core: next-cycle check failed");

`endif

[rtl/core/ttis_pkg.sv]
// Package: sizes, codes, job and texel bundle types for the sampler core
package ttis_pkg;

	localparam int MAX_DIM    = 256;
	localparam int CFG_W      = 9;
	localparam int CFG_IDX_W  = 1;
	localparam int DIM_W      = $clog2(MAX_DIM + 1);
	localparam int POS_W      = $clog2(MAX_DIM);
	localparam int FRAC_W     = 16;
	localparam int COORD_W    = 16;
	localparam int SCL_W      = DIM_W + FRAC_W;
	localparam int ROW_W      = POS_W + DIM_W;
	localparam int ADDR_W     = 16;
	localparam int STORE_DEPTH = 1 << ADDR_W;
	localparam int TEXEL_W    = 32;
	localparam int WGT_W      = FRAC_W + 1;
	localparam int CHAN_W     = 8;
	localparam int NUM_CHAN   = 4;
	localparam int PROD_W     = WGT_W + CHAN_W;
	localparam int ACC_W      = PROD_W + 1;
	localparam int OUT_W      = 16;
	localparam int RND_SHIFT  = 8;
	localparam int S_TDATA_W  = ADDR_W + TEXEL_W + 2 * COORD_W;
	localparam int M_TDATA_W  = NUM_CHAN * OUT_W;

	localparam logic [WGT_W-1:0] ONE_Q16   = WGT_W'(1) << FRAC_W;
	localparam logic [ACC_W-1:0] RND_HALF  = ACC_W'(1) << (RND_SHIFT - 1);
	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'((256 > MAX_DIM) ? MAX_DIM : 256);

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic               op;
		logic [ADDR_W-1:0]  addr_b;
		logic [ADDR_W-1:0]  addr_c;
		logic [ADDR_W-1:0]  addr_a;
		logic [TEXEL_W-1:0] wdata;
		logic [WGT_W-1:0]   wgt_a;
		logic [WGT_W-1:0]   wgt_b;
		logic [WGT_W-1:0]   wgt_c;
	} job_t;

	typedef struct packed {
		logic [TEXEL_W-1:0] tex_a;
		logic [TEXEL_W-1:0] tex_b;
		logic [TEXEL_W-1:0] tex_c;
		logic [WGT_W-1:0]   wgt_a;
		logic [WGT_W-1:0]   wgt_b;
		logic [WGT_W-1:0]   wgt_c;
	} bundle_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
		logic [DIM_W-1:0] r;
		if (d == '0)
			r = DIM_W'(1);
		else if (int'(d) > MAX_DIM)
			r = DIM_W'(MAX_DIM);
		else
			r = DIM_W'(d);
		return r;
	endfunction

endpackage

[rtl/core/ttis_ram.sv]
// Generic single-port synchronous RAM with registered read
module ttis_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we)
				mem_q[addr] <= wdata;
			else
				rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/ttis_addr.sv]
// Coordinate scaling, triangle choice, texel addresses and barycentric weights
module ttis_addr (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          in_op,
	input  logic [ttis_pkg::ADDR_W-1:0]   in_index,
	input  logic [ttis_pkg::TEXEL_W-1:0]  in_rgba,
	input  logic [ttis_pkg::COORD_W-1:0]  in_u,
	input  logic [ttis_pkg::COORD_W-1:0]  in_v,
	input  logic [ttis_pkg::DIM_W-1:0]    tex_w,
	input  logic [ttis_pkg::DIM_W-1:0]    tex_h,
	output logic                          job_valid,
	input  logic                          job_ready,
	output ttis_pkg::job_t                job
);
	import ttis_pkg::*;

	logic               v_s1, v_s2;
	logic               rdy_s1, rdy_s2;
	logic               op_s1;
	logic [ADDR_W-1:0]  index_s1;
	logic [TEXEL_W-1:0] rgba_s1;
	logic [SCL_W-1:0]   sx_s1, sy_s1;
	job_t               job_s2;

	logic [COORD_W-1:0] su, sv;
	logic [POS_W-1:0]   x, y, x1, y1;
	logic [DIM_W-1:0]   xp1, yp1;
	logic [FRAC_W-1:0]  fx, fy;
	logic [WGT_W-1:0]   fsum;
	logic               lower;
	logic [ROW_W-1:0]   row0, row1;
	logic [ADDR_W-1:0]  base0, base1;
	job_t               job_d;

	assign su = {~in_u[COORD_W-1], in_u[COORD_W-2:0]};
	assign sv = {~in_v[COORD_W-1], in_v[COORD_W-2:0]};

	assign rdy_s2   = !v_s2 || job_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1)
				v_s1 <= in_valid;
			if (rdy_s2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			op_s1    <= in_op;
			index_s1 <= in_index;
			rgba_s1  <= in_rgba;
			sx_s1    <= SCL_W'(tex_w) * SCL_W'(su);
			sy_s1    <= SCL_W'(tex_h) * SCL_W'(sv);
		end
	end

	assign x    = sx_s1[FRAC_W +: POS_W];
	assign y    = sy_s1[FRAC_W +: POS_W];
	assign fx   = sx_s1[FRAC_W-1:0];
	assign fy   = sy_s1[FRAC_W-1:0];
	assign xp1  = DIM_W'(x) + DIM_W'(1);
	assign yp1  = DIM_W'(y) + DIM_W'(1);
	assign x1   = (xp1 >= tex_w) ? '0 : xp1[POS_W-1:0];
	assign y1   = (yp1 >= tex_h) ? '0 : yp1[POS_W-1:0];
	assign fsum = WGT_W'(fx) + WGT_W'(fy);
	assign lower = fsum <= ONE_Q16;
	assign row0 = ROW_W'(y) * ROW_W'(tex_w);
	assign row1 = ROW_W'(y1) * ROW_W'(tex_w);
	assign base0 = ADDR_W'(row0);
	assign base1 = ADDR_W'(row1);

	always_comb begin
		job_d.op     = op_s1;
		job_d.wdata  = rgba_s1;
		job_d.addr_c = base0 + ADDR_W'(x1);
		if (op_s1 == OP_WRITE)
			job_d.addr_b = index_s1;
		else
			job_d.addr_b = base1 + ADDR_W'(x);
		if (lower) begin
			job_d.addr_a = base0 + ADDR_W'(x);
			job_d.wgt_a  = ONE_Q16 - fsum;
			job_d.wgt_b  = WGT_W'(fy);
			job_d.wgt_c  = WGT_W'(fx);
		end else begin
			job_d.addr_a = base1 + ADDR_W'(x1);
			job_d.wgt_a  = fsum - ONE_Q16;
			job_d.wgt_b  = ONE_Q16 - WGT_W'(fx);
			job_d.wgt_c  = ONE_Q16 - WGT_W'(fy);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2)
			job_s2 <= job_d;
	end

	assign job_valid = v_s2;
	assign job       = job_s2;

endmodule

[rtl/core/ttis_fetch.sv]
// Texture memory sequencer: one write or three texel reads per job
`include "texture_triangle_interpolated_sampler_core_assert.svh"

module ttis_fetch (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	output logic             job_ready,
	input  ttis_pkg::job_t   job,
	output logic             bnd_valid,
	input  logic             bnd_ready,
	output ttis_pkg::bundle_t bnd
);
	import ttis_pkg::*;

	localparam logic [1:0] SLOT_B = 2'd0;
	localparam logic [1:0] SLOT_C = 2'd1;
	localparam logic [1:0] SLOT_A = 2'd2;

	logic               job_v_q;
	job_t               job_q;
	logic [1:0]         cnt_q;
	logic               rd_v_q;
	logic [1:0]         rd_slot_q;
	logic [TEXEL_W-1:0] tb_q, tc_q;
	logic [WGT_W-1:0]   wa_q, wb_q, wc_q;
	logic               bnd_v_q;
	bundle_t            bnd_q;

	logic               is_wr, bnd_free, issue, done;
	logic               mem_en, mem_we;
	logic [ADDR_W-1:0]  mem_addr;
	logic [TEXEL_W-1:0] mem_rdata;

	assign is_wr     = job_q.op == OP_WRITE;
	assign bnd_free  = !bnd_v_q || bnd_ready;
	assign issue     = job_v_q && (is_wr || cnt_q != SLOT_A || bnd_free);
	assign done      = job_v_q && (is_wr || (cnt_q == SLOT_A && bnd_free));
	assign job_ready = !job_v_q || done;

	assign mem_en = issue;
	assign mem_we = issue && is_wr;

	always_comb begin
		unique case (cnt_q)
			SLOT_B:  mem_addr = job_q.addr_b;
			SLOT_C:  mem_addr = job_q.addr_c;
			default: mem_addr = job_q.addr_a;
		endcase
	end

	ttis_ram #(
		.WIDTH(TEXEL_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.en   (mem_en),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(job_q.wdata),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_v_q   <= 1'b0;
			cnt_q     <= SLOT_B;
			rd_v_q    <= 1'b0;
			rd_slot_q <= SLOT_B;
			bnd_v_q   <= 1'b0;
		end else begin
			if (job_ready)
				job_v_q <= job_valid;
			if (done)
				cnt_q <= SLOT_B;
			else if (issue)
				cnt_q <= cnt_q + 2'd1;
			rd_v_q    <= issue && !is_wr;
			rd_slot_q <= cnt_q;
			if (rd_v_q && rd_slot_q == SLOT_A)
				bnd_v_q <= 1'b1;
			else if (bnd_ready)
				bnd_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && job_ready)
			job_q <= job;
		if (rd_v_q && rd_slot_q == SLOT_B)
			tb_q <= mem_rdata;
		if (rd_v_q && rd_slot_q == SLOT_C)
			tc_q <= mem_rdata;
		if (issue && !is_wr && cnt_q == SLOT_A) begin
			wa_q <= job_q.wgt_a;
			wb_q <= job_q.wgt_b;
			wc_q <= job_q.wgt_c;
		end
		if (rd_v_q && rd_slot_q == SLOT_A) begin
			bnd_q.tex_a <= mem_rdata;
			bnd_q.tex_b <= tb_q;
			bnd_q.tex_c <= tc_q;
			bnd_q.wgt_a <= wa_q;
			bnd_q.wgt_b <= wb_q;
			bnd_q.wgt_c <= wc_q;
		end
	end

	assign bnd_valid = bnd_v_q;
	assign bnd       = bnd_q;

	`TTIS_ASSERT_NEXT(a_last_read_fills, rd_v_q && rd_slot_q == SLOT_A, bnd_v_q)
	`TTIS_ASSERT_NOW(a_no_bundle_overwrite, rd_v_q && rd_slot_q == SLOT_A, !bnd_v_q)
	`TTIS_ASSERT_NOW(a_slot_only_in_sample, cnt_q != SLOT_B, job_v_q && job_q.op == OP_SAMPLE)
	`TTIS_ASSERT_NOW(a_write_in_first_slot, mem_we, cnt_q == SLOT_B)

endmodule

[rtl/core/ttis_blend.sv]
// Barycentric blend of three texels per channel, rounding to 8.8, output register
module ttis_blend (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            bnd_valid,
	output logic                            bnd_ready,
	input  ttis_pkg::bundle_t               bnd,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ttis_pkg::M_TDATA_W-1:0]  out_data
);
	import ttis_pkg::*;

	logic                  v_s1, out_v_q;
	logic                  rdy_s1;
	logic [PROD_W-1:0]     pa_s1 [NUM_CHAN];
	logic [PROD_W-1:0]     pb_s1 [NUM_CHAN];
	logic [PROD_W-1:0]     pc_s1 [NUM_CHAN];
	logic [M_TDATA_W-1:0]  out_q;
	logic [M_TDATA_W-1:0]  out_d;
	logic [ACC_W-1:0]      acc [NUM_CHAN];

	assign rdy_s1    = !out_v_q || out_ready;
	assign bnd_ready = !v_s1 || rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (bnd_ready)
				v_s1 <= bnd_valid;
			if (rdy_s1)
				out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (bnd_valid && bnd_ready) begin
			for (int k = 0; k < NUM_CHAN; k++) begin
				pa_s1[k] <= PROD_W'(bnd.wgt_a) * PROD_W'(bnd.tex_a[CHAN_W*k +: CHAN_W]);
				pb_s1[k] <= PROD_W'(bnd.wgt_b) * PROD_W'(bnd.tex_b[CHAN_W*k +: CHAN_W]);
				pc_s1[k] <= PROD_W'(bnd.wgt_c) * PROD_W'(bnd.tex_c[CHAN_W*k +: CHAN_W]);
			end
		end
	end

	always_comb begin
		for (int k = 0; k < NUM_CHAN; k++) begin
			acc[k] = ACC_W'(pa_s1[k]) + ACC_W'(pb_s1[k]) + ACC_W'(pc_s1[k]) + RND_HALF;
			out_d[OUT_W*k +: OUT_W] = acc[k][RND_SHIFT +: OUT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s1)
			out_q <= out_d;
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

endmodule

[rtl/core/texture_triangle_interpolated_sampler_core.sv]
// Top level: triangle-interpolated RGBA8 texture sampler core
// A write beat (tuser 0) stores one RGBA8 texel through the single texture
// memory port; a sample beat (tuser 1) reads three texels of its cell triangle
// through it, one per cycle, the last once the previous bundle is taken; the
// next beat enters as that read issues. Writes go one per cycle when no sample
// is ahead. A sample passes two address stages, three reads, registered read
// data, one multiply stage and the output register. The texture store is not
// cleared at reset; sample only texels that were written. Width and height
// are clamped to 1..MAX_DIM when written; write them only while the core is idle.
module texture_triangle_interpolated_sampler_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// texel_index[15:0], texel_rgba[47:16], coord_u[63:48], coord_v[79:64]
	input  logic [ttis_pkg::S_TDATA_W-1:0]    s_tdata,
	// opcode[0]
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// red[15:0], green[31:16], blue[47:32], alpha[63:48]
	output logic [ttis_pkg::M_TDATA_W-1:0]    m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ttis_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ttis_pkg::CFG_W-1:0]        cfg_data
);
	import ttis_pkg::*;

	logic [DIM_W-1:0] width_q, height_q;
	logic             job_valid, job_ready;
	job_t             job;
	logic             bnd_valid, bnd_ready;
	bundle_t          bnd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= clamp_dim(cfg_data);
				REG_HEIGHT: height_q <= clamp_dim(cfg_data);
				default:    ;
			endcase
		end
	end

	ttis_addr u_addr (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (s_tuser),
		.in_index (s_tdata[ADDR_W-1:0]),
		.in_rgba  (s_tdata[ADDR_W +: TEXEL_W]),
		.in_u     (s_tdata[ADDR_W + TEXEL_W +: COORD_W]),
		.in_v     (s_tdata[ADDR_W + TEXEL_W + COORD_W +: COORD_W]),
		.tex_w    (width_q),
		.tex_h    (height_q),
		.job_valid(job_valid),
		.job_ready(job_ready),
		.job      (job)
	);

	ttis_fetch u_fetch (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job_ready(job_ready),
		.job      (job),
		.bnd_valid(bnd_valid),
		.bnd_ready(bnd_ready),
		.bnd      (bnd)
	);

	ttis_blend u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.bnd_valid(bnd_valid),
		.bnd_ready(bnd_ready),
		.bnd      (bnd),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (m_tdata)
	);

endmodule
